/* design/bitmap_set_get_count_engine_macros.svh */
// ----------------------------------------------------------------------------
// bitmap set/get/count engine assertion macros
// concurrent check helpers, sampled on clk with rst_n low as disable
// ----------------------------------------------------------------------------
`ifndef BITMAP_SET_GET_COUNT_ENGINE_MACROS_SVH
`define BITMAP_SET_GET_COUNT_ENGINE_MACROS_SVH

// same-cycle implication
`define BSGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bsgc_pkg.sv */
// ----------------------------------------------------------------------------
// bsgc_pkg
// shared constants, word types and helpers of the bitmap engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsgc_pkg;

  // bitmap capacity in bytes
  localparam int MAX_BYTES = 4096;
  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int LEN_W     = $clog2(MAX_BYTES + 1);
  localparam int POS_W     = ADDR_W + 3;
  localparam int UNIT_W    = LEN_W + 3;
  localparam int CNT_W     = $clog2(MAX_BYTES * 8 + 1);
  localparam int RNG_W     = 34;

  // command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_CNT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_PAST_LEN = 2'd2;
  localparam logic [1:0] ST_PAST_CAP = 2'd3;

  // classified operation codes
  localparam logic [2:0] OP_NOP = 3'd0;
  localparam logic [2:0] OP_SET = 3'd1;
  localparam logic [2:0] OP_GET = 3'd2;
  localparam logic [2:0] OP_CNT = 3'd3;
  localparam logic [2:0] OP_CAP = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        bit_index;
    logic               wr_bit;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    logic               byte_mode;
  } bsgc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] answer;
  } bsgc_out_t;

  typedef struct packed {
    logic [2:0]         op;
    logic               over_cap;
    logic [ADDR_W-1:0]  addr;
    logic [2:0]         bit_sel;
    logic               wr_bit;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    logic               byte_mode;
  } bsgc_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bsgc_q_stat_t;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

  function automatic logic [15:0] sat16(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

/* design/bitmap_set_get_count_engine.sv */
// ----------------------------------------------------------------------------
// bitmap_set_get_count_engine
// one growable bitmap with set-bit, get-bit and ranged population count
// ----------------------------------------------------------------------------
//
//   channel  ports                  handshake
//   -------  ---------------------  -------------------------------------
//   input    start, busy, in_data   word taken when start high, busy low
//   result   out_valid, out_data    one-cycle strobe, no back-pressure
//
//   reset starts a clearing pass that writes zero to every store byte,
//     with busy held high throughout
//   set and get strobe a result from their wait state after the store read;
//     words answered without a store read (absent, past length, past capacity,
//     unused command) strobe one straight from idle
//   count resolves the range, then reads the store bytes that the range spans
//     one by one through the single read port of the store
//   the front holds one word and the queue two, so busy rises once both are
//     full, behind a long count or a burst of set and get words
//   results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_set_get_count_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bsgc_pkg::bsgc_in_t  in_data,
  output logic                out_valid,
  output bsgc_pkg::bsgc_out_t out_data
);

  import bsgc_pkg::*;

  // front to queue
  logic         push;
  bsgc_op_t     push_op;

  // queue to back
  bsgc_op_t     head;
  bsgc_q_stat_t q_stat;
  logic         pop;

  // back holds off the front while the store is swept after reset
  logic         clearing;

  // accept and classify command words
  bsgc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .clearing (clearing),
    .q_stat   (q_stat),
    .busy     (busy),
    .push     (push),
    .push_op  (push_op)
  );

  // decouples the front from long count walks
  bsgc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // owns the byte store and the length, produces every result word
  bsgc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* design/bsgc_ram.sv */
// ----------------------------------------------------------------------------
// bsgc_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsgc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4096,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/bsgc_front.sv */
// ----------------------------------------------------------------------------
// bsgc_front
// takes command words, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsgc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  bsgc_pkg::bsgc_in_t    in_data,
  input  logic                  clearing,
  input  bsgc_pkg::bsgc_q_stat_t q_stat,
  output logic                  busy,
  output logic                  push,
  output bsgc_pkg::bsgc_op_t    push_op
);

  import bsgc_pkg::*;

  logic     front_valid_r;
  logic     front_valid_nxt;
  bsgc_in_t item_r;
  logic     accept;
  logic     over_cap;

  assign push   = front_valid_r && !q_stat.full;
  assign busy   = clearing || (front_valid_r && q_stat.full);
  assign accept = start && !busy;

  // byte index past capacity, no length needed
  assign over_cap = item_r.bit_index[31:3] >= 29'(MAX_BYTES);

  always_comb begin
    push_op.over_cap    = over_cap;
    push_op.addr        = item_r.bit_index[ADDR_W+2:3];
    push_op.bit_sel     = item_r.bit_index[2:0];
    push_op.wr_bit      = item_r.wr_bit;
    push_op.range_start = item_r.range_start;
    push_op.range_end   = item_r.range_end;
    push_op.byte_mode   = item_r.byte_mode;
    case (item_r.command)
      CMD_SET: push_op.op = over_cap ? OP_CAP : OP_SET;
      CMD_GET: push_op.op = OP_GET;
      CMD_CNT: push_op.op = OP_CNT;
      default: push_op.op = OP_NOP;
    endcase
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

endmodule

/* design/bsgc_queue.sv */
// ----------------------------------------------------------------------------
// bsgc_queue
// short fifo of classified operations between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsgc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bsgc_pkg::bsgc_op_t     push_op,
  input  logic                   pop,
  output bsgc_pkg::bsgc_op_t     head,
  output bsgc_pkg::bsgc_q_stat_t q_stat
);

  import bsgc_pkg::*;

  bsgc_op_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] fill_r, fill_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = fill_r == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = fill_r == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule

/* design/bsgc_back.sv */
// ----------------------------------------------------------------------------
// bsgc_back
// executes queued operations against the byte store and drives results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_set_get_count_engine_macros.svh"

module bsgc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsgc_pkg::bsgc_op_t     head,
  input  bsgc_pkg::bsgc_q_stat_t q_stat,
  output logic                   pop,
  output logic                   clearing,
  output logic                   out_valid,
  output bsgc_pkg::bsgc_out_t    out_data
);

  import bsgc_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SETW = 3'd2;
  localparam logic [2:0] S_GETW = 3'd3;
  localparam logic [2:0] S_RNG1 = 3'd4;
  localparam logic [2:0] S_RNG2 = 3'd5;
  localparam logic [2:0] S_CNT  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  bsgc_op_t                op_r, op_nxt;
  logic signed [RNG_W-1:0] s1_r, s1_nxt;
  logic signed [RNG_W-1:0] e1_r, e1_nxt;
  logic [POS_W-1:0]        lo_r, lo_nxt;
  logic [POS_W-1:0]        hi_r, hi_nxt;
  logic [ADDR_W-1:0]       cur_r, cur_nxt;
  logic                    issue_done_r, issue_done_nxt;
  logic                    pend_r, pend_nxt;
  logic                    last_r, last_nxt;
  logic [7:0]              mask_r, mask_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r;
  bsgc_out_t               out_r;

  logic                    emit_v;
  bsgc_out_t               emit_d;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [7:0]              wdata;
  logic                    re;
  logic [ADDR_W-1:0]       raddr;
  logic [7:0]              rdata;

  logic [UNIT_W-1:0]       units_b;
  logic signed [RNG_W-1:0] units_s;
  logic signed [RNG_W-1:0] st_s;
  logic signed [RNG_W-1:0] en_s;
  logic signed [RNG_W-1:0] umax_s;
  logic signed [RNG_W-1:0] s2_s;
  logic signed [RNG_W-1:0] e2_s;
  logic                    rng_empty;
  logic [7:0]              new_byte;
  logic [7:0]              cur_mask;
  logic [CNT_W-1:0]        cnt_sum;

  bsgc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign clearing  = state_r == S_CLR;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // range arithmetic, units in bits or bytes
  always_comb begin
    units_b   = op_r.byte_mode ? UNIT_W'(len_r) : {len_r, 3'b000};
    units_s   = $signed({{(RNG_W-UNIT_W){1'b0}}, units_b});
    st_s      = $signed({{(RNG_W-32){op_r.range_start[31]}}, op_r.range_start});
    en_s      = $signed({{(RNG_W-32){op_r.range_end[31]}}, op_r.range_end});
    umax_s    = units_s - RNG_W'(1);
    s2_s      = s1_r[RNG_W-1] ? '0 : s1_r;
    e2_s      = (e1_r > umax_s) ? umax_s : e1_r;
    rng_empty = e2_s[RNG_W-1] || (s2_s > e2_s);
  end

  always_comb begin
    new_byte               = rdata;
    new_byte[~op_r.bit_sel] = op_r.wr_bit;
  end

  // bit mask of the byte being issued in the count walk
  always_comb begin
    cur_mask = 8'hFF;
    if (cur_r == lo_r[POS_W-1:3]) begin
      cur_mask = cur_mask & (8'hFF >> lo_r[2:0]);
    end
    if (cur_r == hi_r[POS_W-1:3]) begin
      cur_mask = cur_mask & (8'hFF << (3'd7 - hi_r[2:0]));
    end
  end

  assign cnt_sum = cnt_r + CNT_W'(pop8(rdata & mask_r));

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    s1_nxt         = s1_r;
    e1_nxt         = e1_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cur_nxt        = cur_r;
    issue_done_nxt = issue_done_r;
    pend_nxt       = 1'b0;
    last_nxt       = last_r;
    mask_nxt       = mask_r;
    cnt_nxt        = cnt_r;
    emit_v         = 1'b0;
    emit_d         = '0;
    we             = 1'b0;
    waddr          = clr_addr_r;
    wdata          = '0;
    re             = 1'b0;
    raddr          = head.addr;

    case (state_r)
      S_CLR: begin
        we = 1'b1;
        if (clr_addr_r == ADDR_W'(MAX_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (pop) begin
          op_nxt = head;
          case (head.op)
            OP_SET: begin
              re        = 1'b1;
              state_nxt = S_SETW;
            end
            OP_GET: begin
              if (len_r == '0) begin
                emit_v        = 1'b1;
                emit_d.status = ST_ABSENT;
              end else if (head.over_cap || (LEN_W'(head.addr) >= len_r)) begin
                emit_v        = 1'b1;
                emit_d.status = ST_PAST_LEN;
              end else begin
                re        = 1'b1;
                state_nxt = S_GETW;
              end
            end
            OP_CNT: begin
              if (len_r == '0) begin
                emit_v        = 1'b1;
                emit_d.status = ST_ABSENT;
              end else begin
                state_nxt = S_RNG1;
              end
            end
            OP_CAP: begin
              emit_v        = 1'b1;
              emit_d.status = ST_PAST_CAP;
            end
            default: begin
              emit_v        = 1'b1;
              emit_d.status = ST_OK;
            end
          endcase
        end
      end

      S_SETW: begin
        we    = 1'b1;
        waddr = op_r.addr;
        wdata = new_byte;
        if (LEN_W'(op_r.addr) >= len_r) begin
          len_nxt = LEN_W'(op_r.addr) + 1'b1;
        end
        emit_v        = 1'b1;
        emit_d.status = ST_OK;
        emit_d.answer = {15'd0, rdata[~op_r.bit_sel]};
        state_nxt     = S_IDLE;
      end

      S_GETW: begin
        emit_v        = 1'b1;
        emit_d.status = ST_OK;
        emit_d.answer = {15'd0, rdata[~op_r.bit_sel]};
        state_nxt     = S_IDLE;
      end

      S_RNG1: begin
        s1_nxt    = st_s + (st_s[RNG_W-1] ? units_s : '0);
        e1_nxt    = en_s + (en_s[RNG_W-1] ? units_s : '0);
        state_nxt = S_RNG2;
      end

      S_RNG2: begin
        if (rng_empty) begin
          emit_v        = 1'b1;
          emit_d.status = ST_OK;
          state_nxt     = S_IDLE;
        end else begin
          if (op_r.byte_mode) begin
            lo_nxt = {s2_s[ADDR_W-1:0], 3'b000};
            hi_nxt = {e2_s[ADDR_W-1:0], 3'b111};
          end else begin
            lo_nxt = s2_s[POS_W-1:0];
            hi_nxt = e2_s[POS_W-1:0];
          end
          cur_nxt        = lo_nxt[POS_W-1:3];
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          state_nxt      = S_CNT;
        end
      end

      S_CNT: begin
        // issue one byte read a cycle, accumulate the byte read last cycle
        if (!issue_done_r) begin
          re             = 1'b1;
          raddr          = cur_r;
          pend_nxt       = 1'b1;
          mask_nxt       = cur_mask;
          last_nxt       = cur_r == hi_r[POS_W-1:3];
          issue_done_nxt = cur_r == hi_r[POS_W-1:3];
          cur_nxt        = cur_r + 1'b1;
        end
        if (pend_r) begin
          cnt_nxt = cnt_sum;
          if (last_r) begin
            emit_v        = 1'b1;
            emit_d.status = ST_OK;
            emit_d.answer = sat16(cnt_sum);
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      len_r        <= '0;
      clr_addr_r   <= '0;
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      clr_addr_r   <= clr_addr_nxt;
      issue_done_r <= issue_done_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    s1_r   <= s1_nxt;
    e1_r   <= e1_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    cur_r  <= cur_nxt;
    last_r <= last_nxt;
    mask_r <= mask_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= emit_d;
  end

  // length stays within capacity
  `BSGC_ASSERT_IMP(a_len_cap, 1'b1, len_r <= LEN_W'(MAX_BYTES), "length past capacity")
  // length never shrinks outside reset
  `BSGC_ASSERT_NXT(a_len_grow, len_r != '0, len_r >= $past(len_r), "length shrank")
  // no result leaves while the store is being cleared
  `BSGC_ASSERT_IMP(a_clr_quiet, state_r == S_CLR, !out_valid_r && !pop, "activity during clear")

endmodule
